/* hdl/calendar_clock_step_counter_top_defines.svh */
// assertion macros used by the checker file
`ifndef CALENDAR_CLOCK_STEP_COUNTER_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_STEP_COUNTER_TOP_DEFINES_SVH

// checked on every edge outside reset
`define CCSC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("calendar counter check failed");

// checked on every edge, reset included
`define CCSC_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("calendar counter reset check failed");

`endif

/* hdl/ccsc_pkg.sv */
package ccsc_pkg;

	// fixed field widths
	localparam int YEAR_W        = 16;
	localparam int YEAR_BITS_DEF = 16;

	// item codes
	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_FWD  = 2'd1,
		MODE_BACK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		UNIT_SEC  = 2'd0,
		UNIT_MIN  = 2'd1,
		UNIT_HOUR = 2'd2,
		UNIT_DAY  = 2'd3
	} unit_t;

	// field limits
	localparam logic [5:0]  SEC_MAX    = 6'd59;
	localparam logic [5:0]  MIN_MAX    = 6'd59;
	localparam logic [4:0]  HOUR_MAX   = 5'd23;
	localparam logic [4:0]  DAY_MAX    = 5'd31;
	localparam logic [3:0]  MONTH_MAX  = 4'd12;
	localparam logic [15:0] RESET_YEAR = 16'd1970;

	// multiplicative inverse of 25 modulo 2^16, for the divisibility test
	localparam logic [15:0] INV25 = 16'h5C29;
	localparam int          DIV25 = 25;

	// input item
	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  unit;
		logic [7:0]  load_second;
		logic [7:0]  load_minute;
		logic [7:0]  load_hour;
		logic [7:0]  load_day;
		logic [7:0]  load_month;
		logic [15:0] load_year;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic        leap_year;
	} out_item_t;

	// time and date without the year
	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic       leap;
	} cal_t;

	// days in a month, february follows the leap flag
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] days;
		case (month)
			4'd2: begin
				days = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				days = 5'd30;
			end
			default: begin
				days = 5'd31;
			end
		endcase
		return days;
	endfunction

endpackage

/* hdl/ccsc_if.sv */
// command channel
interface ccsc_cmd_if;
	logic                valid;
	logic                ready;
	ccsc_pkg::in_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// result channel
interface ccsc_res_if;
	logic                valid;
	logic                ready;
	ccsc_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

/* hdl/ccsc_step.sv */
module ccsc_step #(
	parameter int YEAR_BITS = ccsc_pkg::YEAR_BITS_DEF
) (
	input  ccsc_pkg::in_item_t   item,
	input  ccsc_pkg::cal_t       cur,
	input  logic [YEAR_BITS-1:0] cur_year,
	output ccsc_pkg::cal_t       nxt,
	output logic [YEAR_BITS-1:0] nxt_year
);

	localparam logic [YEAR_BITS-1:0] INV25_W     = ccsc_pkg::INV25[YEAR_BITS-1:0];
	localparam logic [YEAR_BITS-1:0] DIV25_LIMIT =
		YEAR_BITS'(((1 << YEAR_BITS) - 1) / ccsc_pkg::DIV25);

	ccsc_pkg::cal_t       body;
	logic [YEAR_BITS-1:0] year_d;
	logic [YEAR_BITS-1:0] year_prod;
	logic                 by25;
	logic                 leap_d;
	logic                 c_min;
	logic                 c_hour;
	logic                 c_day;
	logic                 c_mon;
	logic [4:0]           last;
	logic [3:0]           prev_month;

	// next date and time, carries and borrows ripple from the chosen unit
	always_comb begin
		body       = cur;
		year_d     = cur_year;
		c_min      = 1'b0;
		c_hour     = 1'b0;
		c_day      = 1'b0;
		c_mon      = 1'b0;
		last       = ccsc_pkg::month_days(cur.month, cur.leap);
		prev_month = (cur.month == 4'd1) ? ccsc_pkg::MONTH_MAX : cur.month - 4'd1;
		case (item.mode)
			ccsc_pkg::MODE_LOAD: begin
				body.sec  = (item.load_second > 8'(ccsc_pkg::SEC_MAX)) ?
					ccsc_pkg::SEC_MAX : item.load_second[5:0];
				body.min  = (item.load_minute > 8'(ccsc_pkg::MIN_MAX)) ?
					ccsc_pkg::MIN_MAX : item.load_minute[5:0];
				body.hour = (item.load_hour > 8'(ccsc_pkg::HOUR_MAX)) ?
					ccsc_pkg::HOUR_MAX : item.load_hour[4:0];
				if (item.load_day == 8'd0) begin
					body.day = 5'd1;
				end else if (item.load_day > 8'(ccsc_pkg::DAY_MAX)) begin
					body.day = ccsc_pkg::DAY_MAX;
				end else begin
					body.day = item.load_day[4:0];
				end
				if (item.load_month == 8'd0) begin
					body.month = 4'd1;
				end else if (item.load_month > 8'(ccsc_pkg::MONTH_MAX)) begin
					body.month = ccsc_pkg::MONTH_MAX;
				end else begin
					body.month = item.load_month[3:0];
				end
				year_d = item.load_year[YEAR_BITS-1:0];
			end
			ccsc_pkg::MODE_FWD: begin
				// seconds
				if (item.unit == ccsc_pkg::UNIT_SEC) begin
					body.sec = (cur.sec >= ccsc_pkg::SEC_MAX) ? 6'd0 : cur.sec + 6'd1;
				end
				c_min = (item.unit == ccsc_pkg::UNIT_MIN) ||
					((item.unit == ccsc_pkg::UNIT_SEC) && (cur.sec >= ccsc_pkg::SEC_MAX));
				// minutes
				if (c_min) begin
					body.min = (cur.min >= ccsc_pkg::MIN_MAX) ? 6'd0 : cur.min + 6'd1;
				end
				c_hour = (item.unit == ccsc_pkg::UNIT_HOUR) ||
					(c_min && (cur.min >= ccsc_pkg::MIN_MAX));
				// hours
				if (c_hour) begin
					body.hour = (cur.hour >= ccsc_pkg::HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
				end
				c_day = (item.unit == ccsc_pkg::UNIT_DAY) ||
					(c_hour && (cur.hour >= ccsc_pkg::HOUR_MAX));
				// days, an over-long loaded day also rolls to the next month
				if (c_day) begin
					if (cur.day >= last) begin
						body.day = 5'd1;
						c_mon    = 1'b1;
					end else begin
						body.day = cur.day + 5'd1;
					end
				end
				// months and year
				if (c_mon) begin
					if (cur.month >= ccsc_pkg::MONTH_MAX) begin
						body.month = 4'd1;
						year_d     = cur_year + YEAR_BITS'(1);
					end else begin
						body.month = cur.month + 4'd1;
					end
				end
			end
			ccsc_pkg::MODE_BACK: begin
				// seconds
				if (item.unit == ccsc_pkg::UNIT_SEC) begin
					body.sec = (cur.sec == 6'd0) ? ccsc_pkg::SEC_MAX : cur.sec - 6'd1;
				end
				c_min = (item.unit == ccsc_pkg::UNIT_MIN) ||
					((item.unit == ccsc_pkg::UNIT_SEC) && (cur.sec == 6'd0));
				// minutes
				if (c_min) begin
					body.min = (cur.min == 6'd0) ? ccsc_pkg::MIN_MAX : cur.min - 6'd1;
				end
				c_hour = (item.unit == ccsc_pkg::UNIT_HOUR) ||
					(c_min && (cur.min == 6'd0));
				// hours
				if (c_hour) begin
					body.hour = (cur.hour == 5'd0) ? ccsc_pkg::HOUR_MAX : cur.hour - 5'd1;
				end
				c_day = (item.unit == ccsc_pkg::UNIT_DAY) ||
					(c_hour && (cur.hour == 5'd0));
				// days, a borrow lands on the last day of the previous month
				if (c_day) begin
					if (cur.day == 5'd1) begin
						body.month = prev_month;
						body.day   = ccsc_pkg::month_days(prev_month, cur.leap);
						if (cur.month == 4'd1) begin
							year_d = cur_year - YEAR_BITS'(1);
						end
					end else begin
						body.day = cur.day - 5'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// leap test: divisible by 4, and by 16 whenever divisible by 25
	assign year_prod = year_d * INV25_W;
	assign by25      = (year_prod <= DIV25_LIMIT);
	assign leap_d    = (year_d[1:0] == 2'b00) && (!by25 || (year_d[3:0] == 4'b0000));

	assign nxt = '{
		sec:   body.sec,
		min:   body.min,
		hour:  body.hour,
		day:   body.day,
		month: body.month,
		leap:  leap_d
	};
	assign nxt_year = year_d;

endmodule

/* hdl/calendar_clock_step_counter_top.sv */
// Calendar clock step counter. Holds second, minute, hour, day, month, a
// YEAR_BITS-bit year and its Gregorian leap flag; each command item loads a
// clamped date-time or steps it one second, minute, hour or day forward or
// back, and every item returns one result item with the value after it.
// Throughput is one item per clock while the result side keeps up: an
// item is held in the input register, then the whole carry or borrow chain
// and the leap test (one YEAR_BITS-wide multiply by the inverse of 25) run
// combinationally into the state and result registers, so a result is
// offered from the result register. The input stalls only while both the
// input and the result register hold an item and the result is not taken.
// After reset the value is 00:00:00 on January 1, 1970.
module calendar_clock_step_counter_top #(
	parameter int YEAR_BITS = ccsc_pkg::YEAR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ccsc_cmd_if.sink      cmd,
	ccsc_res_if.source    res
);

	logic                 valid_s1;
	ccsc_pkg::in_item_t   item_s1;
	ccsc_pkg::cal_t       cal_q;
	logic [YEAR_BITS-1:0] year_q;
	ccsc_pkg::cal_t       cal_d;
	logic [YEAR_BITS-1:0] year_d;
	logic                 res_valid_q;
	ccsc_pkg::out_item_t  res_item_q;
	logic [ccsc_pkg::YEAR_W-1:0] year_ext;
	logic                 advance;

	// the held item moves on when the result register is free or drains
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.item;
		end
	end

	// next value
	ccsc_step #(
		.YEAR_BITS (YEAR_BITS)
	) u_step (
		.item     (item_s1),
		.cur      (cal_q),
		.cur_year (year_q),
		.nxt      (cal_d),
		.nxt_year (year_d)
	);

	// calendar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1,
				leap: 1'b0};
			year_q <= ccsc_pkg::RESET_YEAR[YEAR_BITS-1:0];
		end else if (advance) begin
			cal_q  <= cal_d;
			year_q <= year_d;
		end
	end

	// year widened to the result field
	always_comb begin
		year_ext                = '0;
		year_ext[YEAR_BITS-1:0] = year_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_item_q <= '{
				second:    cal_d.sec,
				minute:    cal_d.min,
				hour:      cal_d.hour,
				day:       cal_d.day,
				month:     cal_d.month,
				year:      year_ext,
				leap_year: cal_d.leap
			};
		end
	end

	assign res.valid = res_valid_q;
	assign res.item  = res_item_q;

endmodule

/* hdl/ccsc_checker.sv */
`include "calendar_clock_step_counter_top_defines.svh"

module ccsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                res_valid,
	input logic                res_ready,
	input ccsc_pkg::out_item_t res_item
);

	logic [1:0] pend_q;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if ((cmd_valid && cmd_ready) && !(res_valid && res_ready)) begin
			pend_q <= pend_q + 2'd1;
		end else if (!(cmd_valid && cmd_ready) && (res_valid && res_ready)) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// never more than the input and result registers can hold
	`CCSC_ASSERT(a_pend_bound, pend_q != 2'd3)

	// an empty block takes items and shows no result
	`CCSC_ASSERT(a_empty_idle, (pend_q == 2'd0) |-> (cmd_ready && !res_valid))

	// a stalled result stays put
	`CCSC_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_item)))

	// a leap year is a multiple of four
	`CCSC_ASSERT(a_leap_div4, (res_valid && res_item.leap_year) |-> (res_item.year[1:0] == 2'b00))

	// no result during reset
	`CCSC_ASSERT_RST(a_reset_quiet, !arst_n |-> !res_valid)

endmodule

bind calendar_clock_step_counter_top ccsc_checker u_ccsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.item)
);

/* bench/calendar_clock_step_counter_top_tb.sv */
`timescale 1ns / 100ps

module calendar_clock_step_counter_top_tb;
	import ccsc_pkg::*;

	// mode code with no operation behind it
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int         REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n;

	ccsc_cmd_if cmd_ch();
	ccsc_res_if res_ch();

	calendar_clock_step_counter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// predicted calendar value and the values still to come out
	out_item_t cal;
	out_item_t pending_times[$];
	out_item_t want_time;
	int        bad_results = 0;

	// idle and hold-off controls
	bit cmd_gaps     = 1'b0;
	bit res_gaps     = 1'b0;
	bit stall_req    = 1'b0;
	int stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// calendar predictor
	// ---------------------------------------------------------------

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		if (m == 4'd2) begin
			n = leap ? 5'd29 : 5'd28;
		end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
			n = 5'd30;
		end else begin
			n = 5'd31;
		end
		return n;
	endfunction

	function automatic void set_year(input logic [15:0] y);
		cal.year      = y;
		cal.leap_year = (y % 16'd400 == 16'd0) ||
			((y % 16'd4 == 16'd0) && (y % 16'd100 != 16'd0));
	endfunction

	// day carry, a day past the month length also rolls over
	function automatic void day_up();
		if (cal.day >= days_in(cal.month, cal.leap_year)) begin
			cal.day = 5'd1;
			if (cal.month == MONTH_MAX) begin
				cal.month = 4'd1;
				set_year(cal.year + 16'd1);
			end else begin
				cal.month = cal.month + 4'd1;
			end
		end else begin
			cal.day = cal.day + 5'd1;
		end
	endfunction

	// day borrow, month and leap flag settle before the new day is taken
	function automatic void day_down();
		if (cal.day == 5'd1) begin
			if (cal.month == 4'd1) begin
				cal.month = MONTH_MAX;
				set_year(cal.year - 16'd1);
			end else begin
				cal.month = cal.month - 4'd1;
			end
			cal.day = days_in(cal.month, cal.leap_year);
		end else begin
			cal.day = cal.day - 5'd1;
		end
	endfunction

	function automatic void apply_cmd(input in_item_t it);
		int lvl;
		bit chain;
		lvl   = int'(it.unit);
		chain = 1'b1;
		case (it.mode)
			MODE_LOAD: begin
				cal.second = (it.load_second > 8'd59) ? SEC_MAX : it.load_second[5:0];
				cal.minute = (it.load_minute > 8'd59) ? MIN_MAX : it.load_minute[5:0];
				cal.hour   = (it.load_hour > 8'd23) ? HOUR_MAX : it.load_hour[4:0];
				cal.day    = (it.load_day == 8'd0) ? 5'd1 :
					(it.load_day > 8'd31) ? DAY_MAX : it.load_day[4:0];
				cal.month  = (it.load_month == 8'd0) ? 4'd1 :
					(it.load_month > 8'd12) ? MONTH_MAX : it.load_month[3:0];
				set_year(it.load_year);
			end
			MODE_FWD: begin
				if (lvl == 0) begin
					chain      = (cal.second == SEC_MAX);
					cal.second = chain ? 6'd0 : cal.second + 6'd1;
				end
				if (chain && lvl <= 1) begin
					chain      = (cal.minute == MIN_MAX);
					cal.minute = chain ? 6'd0 : cal.minute + 6'd1;
				end
				if (chain && lvl <= 2) begin
					chain    = (cal.hour == HOUR_MAX);
					cal.hour = chain ? 5'd0 : cal.hour + 5'd1;
				end
				if (chain) begin
					day_up();
				end
			end
			MODE_BACK: begin
				if (lvl == 0) begin
					chain      = (cal.second == 6'd0);
					cal.second = chain ? SEC_MAX : cal.second - 6'd1;
				end
				if (chain && lvl <= 1) begin
					chain      = (cal.minute == 6'd0);
					cal.minute = chain ? MIN_MAX : cal.minute - 6'd1;
				end
				if (chain && lvl <= 2) begin
					chain    = (cal.hour == 5'd0);
					cal.hour = chain ? HOUR_MAX : cal.hour - 5'd1;
				end
				if (chain) begin
					day_down();
				end
			end
			default: begin
			end
		endcase
		pending_times.push_back(cal);
	endfunction

	// ---------------------------------------------------------------
	// item builders
	// ---------------------------------------------------------------

	function automatic in_item_t rand_fields();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[59:0];
	endfunction

	function automatic in_item_t load_at(input int s, input int m, input int h,
			input int d, input int mo, input int y);
		in_item_t it;
		it             = rand_fields();
		it.mode        = MODE_LOAD;
		it.load_second = 8'(s);
		it.load_minute = 8'(m);
		it.load_hour   = 8'(h);
		it.load_day    = 8'(d);
		it.load_month  = 8'(mo);
		it.load_year   = 16'(y);
		return it;
	endfunction

	function automatic in_item_t step_item(input logic [1:0] md, input unit_t u);
		in_item_t it;
		it      = rand_fields();
		it.mode = md;
		it.unit = u;
		return it;
	endfunction

	// load close to a rollover in either direction, sometimes raw
	function automatic in_item_t edge_load();
		in_item_t it;
		it      = rand_fields();
		it.mode = MODE_LOAD;
		if ($urandom_range(0, 3) != 0) begin
			it.load_second = 8'($urandom_range(0, 1) ? $urandom_range(55, 59) : $urandom_range(0, 4));
			it.load_minute = 8'($urandom_range(0, 1) ? $urandom_range(57, 59) : $urandom_range(0, 2));
			it.load_hour   = 8'($urandom_range(0, 1) ? $urandom_range(22, 23) : $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: it.load_day = 8'($urandom_range(1, 2));
				1: it.load_day = 8'($urandom_range(27, 31));
				default: it.load_day = 8'($urandom_range(1, 31));
			endcase
			case ($urandom_range(0, 3))
				0: it.load_month = 8'd2;
				1: it.load_month = 8'd12;
				2: it.load_month = 8'd1;
				default: it.load_month = 8'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 5))
				0: it.load_year = 16'd0;
				1: it.load_year = 16'hFFFF;
				2: it.load_year = 16'd2000;
				3: it.load_year = 16'd1900;
				4: it.load_year = 16'($urandom) & 16'hFFFC;
				default: it.load_year = 16'($urandom);
			endcase
		end
		return it;
	endfunction

	function automatic in_item_t random_step();
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 46) begin
			it = step_item(MODE_FWD, unit_t'($urandom_range(0, 3)));
		end else if (r < 92) begin
			it = step_item(MODE_BACK, unit_t'($urandom_range(0, 3)));
		end else if (r < 96) begin
			it = step_item(MODE_SPARE, unit_t'($urandom_range(0, 3)));
		end else begin
			it      = rand_fields();
			it.mode = MODE_LOAD;
		end
		return it;
	endfunction

	// ---------------------------------------------------------------
	// command driver, called at a falling edge and returns at one
	// ---------------------------------------------------------------

	task automatic send_cmd(input in_item_t it);
		if (cmd_gaps && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.item  <= it;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
		apply_cmd(it);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// result side: ready pattern and checking
	// ---------------------------------------------------------------

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				res_ch.ready <= 1'b0;
				for (int n = 0; n < stall_cycles; n++) begin
					@(negedge clk);
				end
			end else if (res_gaps && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_times.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_MAX) begin
					$display("%0t: result item with nothing expected: %0d:%0d:%0d %0d-%0d-%0d leap %0b",
						$realtime, res_ch.item.hour, res_ch.item.minute, res_ch.item.second,
						res_ch.item.year, res_ch.item.month, res_ch.item.day,
						res_ch.item.leap_year);
				end
			end else begin
				want_time = pending_times.pop_front();
				if (res_ch.item.second !== want_time.second ||
						res_ch.item.minute !== want_time.minute ||
						res_ch.item.hour !== want_time.hour ||
						res_ch.item.day !== want_time.day ||
						res_ch.item.month !== want_time.month ||
						res_ch.item.year !== want_time.year ||
						res_ch.item.leap_year !== want_time.leap_year) begin
					bad_results++;
					if (bad_results <= REPORT_MAX) begin
						$display("%0t: mismatch, expected %0d:%0d:%0d %0d-%0d-%0d leap %0b, got %0d:%0d:%0d %0d-%0d-%0d leap %0b",
							$realtime,
							want_time.hour, want_time.minute, want_time.second,
							want_time.year, want_time.month, want_time.day,
							want_time.leap_year,
							res_ch.item.hour, res_ch.item.minute, res_ch.item.second,
							res_ch.item.year, res_ch.item.month, res_ch.item.day,
							res_ch.item.leap_year);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// spare mode only reports the value after reset
	task automatic test_reset_value();
		send_cmd(step_item(MODE_SPARE, unit_t'($urandom_range(0, 3))));
	endtask

	// second to month pushed past the top of their range, day and month past the bottom too
	task automatic test_load_clamp();
		send_cmd(load_at(255, 255, 255, 255, 255, 65535));
		send_cmd(load_at(60, 60, 24, 32, 13, 1));
		send_cmd(load_at(0, 0, 0, 0, 0, 0));
		send_cmd(step_item(MODE_SPARE, UNIT_DAY));
	endtask

	// february 29 in 2000, a leap century year, not in 1900
	task automatic test_leap_days();
		send_cmd(load_at(0, 0, 12, 28, 2, 2000));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
		send_cmd(step_item(MODE_BACK, UNIT_DAY));
		send_cmd(load_at(0, 0, 12, 28, 2, 1900));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
	endtask

	// a loaded day past the month end is kept as it is
	task automatic test_day_overrun();
		send_cmd(load_at(30, 30, 6, 31, 2, 2023));
		send_cmd(step_item(MODE_BACK, UNIT_DAY));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
		send_cmd(load_at(0, 0, 0, 31, 4, 2023));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
	endtask

	// year rolls over at the top of the range and back
	task automatic test_year_wrap();
		send_cmd(load_at(59, 59, 23, 31, 12, 65535));
		send_cmd(step_item(MODE_FWD, UNIT_SEC));
		send_cmd(step_item(MODE_BACK, UNIT_SEC));
		send_cmd(step_item(MODE_FWD, UNIT_DAY));
		send_cmd(step_item(MODE_BACK, UNIT_DAY));
	endtask

	// minute and hour steps carry into the month
	task automatic test_carry_chain();
		send_cmd(load_at(59, 59, 23, 30, 4, 2021));
		send_cmd(step_item(MODE_FWD, UNIT_MIN));
		send_cmd(step_item(MODE_BACK, UNIT_HOUR));
		send_cmd(step_item(MODE_FWD, UNIT_HOUR));
		send_cmd(step_item(MODE_BACK, UNIT_MIN));
	endtask

	// loads near a rollover followed by runs of steps
	task automatic test_random_walk(input int n_runs);
		int steps;
		for (int i = 0; i < n_runs; i++) begin
			send_cmd(edge_load());
			steps = $urandom_range(6, 14);
			for (int k = 0; k < steps; k++) begin
				send_cmd(random_step());
			end
		end
	endtask

	// result side held off while commands keep coming
	task automatic test_output_stall();
		cmd_gaps     = 1'b0;
		stall_cycles = 80;
		stall_req    = 1'b1;
		send_cmd(edge_load());
		for (int i = 0; i < 39; i++) begin
			send_cmd(random_step());
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.item  <= '0;
		arst_n       <= 1'b0;
		cal.second    = 6'd0;
		cal.minute    = 6'd0;
		cal.hour      = 5'd0;
		cal.day       = 5'd1;
		cal.month     = 4'd1;
		set_year(RESET_YEAR);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cmd_gaps = 1'b1;
		res_gaps = 1'b1;
		test_reset_value();
		test_load_clamp();
		test_leap_days();
		test_day_overrun();
		test_year_wrap();
		test_carry_chain();
		test_random_walk(120);
		test_output_stall();
		cmd_gaps = 1'b1;
		test_random_walk(8);

		// closing stretch at full rate
		cmd_gaps = 1'b0;
		res_gaps = 1'b0;
		test_random_walk(22);
		cmd_ch.valid <= 1'b0;

		while (pending_times.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (bad_results == 0 && pending_times.size() == 0) begin
			$display("calendar_clock_step_counter_top_tb: PASS");
		end else begin
			$display("calendar_clock_step_counter_top_tb: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("calendar_clock_step_counter_top_tb: FAIL");
		$finish;
	end

endmodule
